// ----- src/rls_pkg.sv -----
// Shared types and constants for the run-length smoothing line block.
package rls_pkg;

   localparam int RUN_LIMIT_W = 6;
   localparam logic [RUN_LIMIT_W-1:0] RUN_LIMIT_RESET = 6'd8;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic step;   // take one input beat this cycle
      logic pop;    // move the oldest queued pixel to the output register
   } rls_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;     // output register can take a beat this cycle
      logic line_last;    // the offered input beat closes its line
      logic flush_last;   // the next pop is the final pixel of the line
   } rls_status_type;

endpackage

// ----- src/run_length_smoothing_line_core.sv -----
// Run-length smoothing of a binary pixel line: top level.
//
// Input channel (req_): one pixel per beat, 1 black, 0 white, with
// req_line_end_in on the last pixel of a line or column.
// Result channel (rsp_): smoothed pixels in line order, rsp_line_end_out on
// the last pixel of each line. A white pixel goes black when its white run
// is shorter than c; runs open at either line end stay white.
// Configuration: csr_write_data is the run limit c, taken at the first pixel
// of each line and clipped to MAX_RUN. Write it only while the block is idle.
// Rate: one pixel a cycle inside a line while rsp_ is not stalled. A result
// leaves c pixels after its input, via one output register: rsp_valid rises
// in the cycle after acceptance. The last pixel of a line stops input while
// the queue drains one pixel a cycle unless rsp_ stalls; that drain sets the
// line cost. A line longer than MAX_LINE is cut after MAX_LINE pixels.
// Reset (synchronous, active high) empties the queue, clears the output and
// sets c to 8. A stall on rsp_ holds the output beat and, through req_stall,
// holds the input side in the same cycle.
module run_length_smoothing_line_core #(
   parameter int MAX_RUN  = 63,
   parameter int MAX_LINE = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rls_pkg::RUN_LIMIT_W-1:0] csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_pixel_in,
   input  logic                            req_line_end_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pixel_out,
   output logic                            rsp_line_end_out
);
   import rls_pkg::*;

   rls_cmd_type    cmd;
   rls_status_type status;

   rls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rls_datapath #(
      .MAX_RUN  (MAX_RUN),
      .MAX_LINE (MAX_LINE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_pixel_in     (req_pixel_in),
      .req_line_end_in  (req_line_end_in),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_line_end_out (rsp_line_end_out)
   );

endmodule

// ----- src/rls_ctrl.sv -----
// Controller: accepts pixels while streaming, drains the queue after a line end.
module rls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rls_pkg::rls_status_type status,
   output rls_pkg::rls_cmd_type    cmd
);
   import rls_pkg::*;

   localparam logic ST_STREAM = 1'b0;
   localparam logic ST_FLUSH  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_STREAM: begin
            req_stall = !status.out_free;
            cmd.step  = req_valid && status.out_free;
            if (cmd.step && status.line_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.pop = status.out_free;
            if (cmd.pop && status.flush_last) begin
               state_in = ST_STREAM;
            end
         end
         default: state_in = ST_STREAM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STREAM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/rls_datapath.sv -----
// Datapath: run tracking, pixel queue with run fill, line counters and output register.
module rls_datapath #(
   parameter int MAX_RUN  = 63,
   parameter int MAX_LINE = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [rls_pkg::RUN_LIMIT_W-1:0]   csr_write_data,
   input  logic                              req_pixel_in,
   input  logic                              req_line_end_in,
   input  rls_pkg::rls_cmd_type              cmd,
   output rls_pkg::rls_status_type           status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic                              rsp_pixel_out,
   output logic                              rsp_line_end_out
);
   import rls_pkg::*;

   localparam int DEPTH = MAX_RUN + 1;
   localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LPW   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
   localparam logic [CW-1:0]  C_MAX    = CW'(MAX_RUN);
   localparam logic [LPW-1:0] POS_LAST = LPW'(MAX_LINE - 1);

   logic [RUN_LIMIT_W-1:0] run_limit_ff;
   logic [CW-1:0]          line_c_ff, line_c_in;
   logic [LPW-1:0]         line_pos_ff, line_pos_in;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [CW-1:0]          run_len_ff, run_len_in;
   logic                   at_start_ff, at_start_in;
   logic [DEPTH-1:0]       queue_ff, queue_in, moved;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_pixel_ff, out_pixel_in;
   logic                   out_line_end_ff, out_line_end_in;

   logic [CW-1:0] c_sat;
   logic [CW-1:0] c_eff;
   logic [CW-1:0] top;
   logic          line_first;
   logic          last;
   logic          occ_full;
   logic          emit;
   logic          shift;
   logic          store;
   logic          blacken;
   logic          emit_pixel;
   logic          out_free;

   assign c_sat      = (run_limit_ff > RUN_LIMIT_W'(MAX_RUN)) ? C_MAX : CW'(run_limit_ff);
   assign line_first = (line_pos_ff == '0);
   // c is taken at the first pixel of a line and held to its end
   assign c_eff      = line_first ? c_sat : line_c_ff;
   assign last       = req_line_end_in || (line_pos_ff == POS_LAST);
   assign occ_full   = (occ_ff == c_eff);
   assign emit       = !last && occ_full;
   assign shift      = emit && (c_eff != '0);
   assign store      = !(emit && (c_eff == '0));
   assign top        = shift ? (c_eff - CW'(1)) : occ_ff;
   // a black pixel closes a white run; fill it if it is short and not open at the line start
   assign blacken    = req_pixel_in && !at_start_ff && (run_len_ff != '0)
                       && (run_len_ff < c_eff);
   assign emit_pixel = (c_eff == '0) ? req_pixel_in : queue_ff[0];
   assign out_free   = !out_valid_ff || !rsp_stall;

   assign status.out_free   = out_free;
   assign status.line_last  = last;
   assign status.flush_last = (occ_ff == '0);

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_out    = out_pixel_ff;
   assign rsp_line_end_out = out_line_end_ff;

   // pixel queue: oldest at bit 0, new pixel lands at top, short runs below top go black
   always_comb begin
      moved = queue_ff;
      if ((cmd.step && shift) || cmd.pop) begin
         moved = queue_ff >> 1;
      end
      queue_in = moved;
      if (cmd.step) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (store && (CW'(i) == top)) begin
               queue_in[i] = req_pixel_in;
            end else if (blacken && (CW'(i) < top)
                         && (((CW+1)'(i) + (CW+1)'(run_len_ff)) >= (CW+1)'(top))) begin
               queue_in[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      occ_in      = occ_ff;
      line_pos_in = line_pos_ff;
      line_c_in   = line_c_ff;
      run_len_in  = run_len_ff;
      at_start_in = at_start_ff;
      if (cmd.step) begin
         line_c_in = c_eff;
         if (last) begin
            // occ now indexes the last queued pixel; flush counts it down
            line_pos_in = '0;
            run_len_in  = '0;
            at_start_in = 1'b1;
         end else begin
            line_pos_in = line_pos_ff + LPW'(1);
            if (!occ_full) begin
               occ_in = occ_ff + CW'(1);
            end
            if (req_pixel_in) begin
               run_len_in  = '0;
               at_start_in = 1'b0;
            end else if (run_len_ff != C_MAX) begin
               run_len_in = run_len_ff + CW'(1);
            end
         end
      end else if (cmd.pop && (occ_ff != '0)) begin
         occ_in = occ_ff - CW'(1);
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff && rsp_stall;
      out_pixel_in    = out_pixel_ff;
      out_line_end_in = out_line_end_ff;
      if (cmd.step && emit) begin
         out_valid_in    = 1'b1;
         out_pixel_in    = emit_pixel;
         out_line_end_in = 1'b0;
      end else if (cmd.pop) begin
         out_valid_in    = 1'b1;
         out_pixel_in    = queue_ff[0];
         out_line_end_in = (occ_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_limit_ff <= RUN_LIMIT_RESET;
         line_c_ff    <= '0;
         line_pos_ff  <= '0;
         occ_ff       <= '0;
         run_len_ff   <= '0;
         at_start_ff  <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            run_limit_ff <= csr_write_data;
         end
         line_c_ff    <= line_c_in;
         line_pos_ff  <= line_pos_in;
         occ_ff       <= occ_in;
         run_len_ff   <= run_len_in;
         at_start_ff  <= at_start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff        <= queue_in;
      out_pixel_ff    <= out_pixel_in;
      out_line_end_ff <= out_line_end_in;
   end

endmodule

// ----- src/rls_checker.sv -----
// Port-level checks for the run-length smoothing line block, bound to the top level.
module rls_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_line_end_in,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_pixel_out,
   input logic rsp_line_end_out
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_line_end_out))
      else $error("stalled result beat changed");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a line end starts the drain, which holds the input side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_line_end_in |=> req_stall)
      else $error("input taken right after a line end");

   // input is taken only when the output register can move
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid || !rsp_stall)
      else $error("input open while output blocked");

endmodule

bind run_length_smoothing_line_core rls_checker u_rls_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_line_end_in  (req_line_end_in),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_out    (rsp_pixel_out),
   .rsp_line_end_out (rsp_line_end_out)
);

// ----- tb/sv/run_length_smoothing_line_core_tb.sv -----
// Self-checking testbench for the run-length smoothing line core.
module run_length_smoothing_line_core_tb;
   import rls_pkg::*;

   localparam int MAX_RUN    = 63;
   localparam int MAX_LINE   = 4096;
   localparam int WIN_DEPTH  = 2 * MAX_RUN + 1;
   localparam int SETTLE     = 12;
   localparam int CYCLE_CAP  = 1000000;

   typedef struct packed {
      bit pixel;
      bit line_end;
   } smooth_beat_type;

   // Line-level smoothing predictor and store of pending smoothed beats
   class smooth_scoreboard_type;
      int unsigned run_limit;
      int unsigned line_c;
      int unsigned line_pos;
      int unsigned emit_pos;
      bit line_px[MAX_LINE];
      smooth_beat_type pending_beats[$];
      int errors;
      int checked;

      function new();
         run_limit = RUN_LIMIT_RESET;
         line_c = 0;
         line_pos = 0;
         emit_pos = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_limit(int unsigned v);
         run_limit = v & 63;
      endfunction

      function bit pixel_at(int q, int newest);
         if (q < 0 || q > newest || newest - q >= WIN_DEPTH) return 1'b0;
         return line_px[q];
      endfunction

      function bit smoothed(int p, int newest, int c);
         int count;
         count = 0;
         if (pixel_at(p, newest)) return 1'b1;
         for (int k = -c; k <= c; k++) begin
            if (!pixel_at(p + k, newest)) count++;
            else count = 0;
            if (count >= c) break;
         end
         return count < c;
      endfunction

      function void note_pixel(bit px, bit last);
         int pos;
         int c;
         int n;
         smooth_beat_type b;
         // latch c on the first pixel of each line
         if (line_pos == 0) line_c = (run_limit > MAX_RUN) ? MAX_RUN : run_limit;
         if (line_pos >= MAX_LINE - 1) last = 1'b1;
         line_px[line_pos] = px;
         pos = line_pos;
         c = line_c;
         if (!last) begin
            if (pos >= c) begin
               b.pixel = smoothed(pos - c, pos, c);
               b.line_end = 1'b0;
               pending_beats.push_back(b);
               emit_pos = pos - c + 1;
            end
            line_pos++;
         end else begin
            n = 0;
            // flush everything still owed for this line
            for (int p = emit_pos; p <= pos && n < 64; p++) begin
               b.pixel = smoothed(p, pos, c);
               b.line_end = (p == pos);
               pending_beats.push_back(b);
               n++;
            end
            line_pos = 0;
            emit_pos = 0;
         end
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_beat(bit px, bit le);
         smooth_beat_type want;
         if (pending_beats.size() == 0) begin
            report($sformatf("beat %0d arrived with nothing pending (pixel %0b, end %0b)",
                             checked, px, le));
         end else begin
            want = pending_beats.pop_front();
            if (px != want.pixel)
               report($sformatf("beat %0d: pixel_out %0b, expected %0b",
                                checked, px, want.pixel));
            if (le != want.line_end)
               report($sformatf("beat %0d: line_end_out %0b, expected %0b",
                                checked, le, want.line_end));
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [RUN_LIMIT_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_pixel_in = 1'b0;
   logic req_line_end_in = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_pixel_out;
   logic rsp_line_end_out;

   smooth_scoreboard_type sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int pixels_sent = 0;
   int lines_sent = 0;
   int limit_writes = 0;

   run_length_smoothing_line_core #(
      .MAX_RUN  (MAX_RUN),
      .MAX_LINE (MAX_LINE)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_in     (req_pixel_in),
      .req_line_end_in  (req_line_end_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_line_end_out (rsp_line_end_out)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watch both channels at each edge, before any drive of this step lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_pixel(req_pixel_in, req_line_end_in);
         if (rsp_valid && !rsp_stall) sb.check_beat(rsp_pixel_out, rsp_line_end_out);
      end
   end

   initial begin
      repeat (CYCLE_CAP) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_CAP);
      $display("status: fail");
      $finish;
   end

   task send_pixel(input bit px, input bit le);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_pixel_in <= $urandom_range(1);
         req_line_end_in <= $urandom_range(1);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= px;
      req_line_end_in <= le;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
      if (le) lines_sent++;
   endtask

   task send_line(input bit [31:0] bits, input int len);
      for (int i = 0; i < len; i++) send_pixel(bits[i], i == len - 1);
   endtask

   task wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_beats.size() != 0) @(posedge clock);
      // the block may still hold pixels that owe no beat yet
      repeat (SETTLE) @(posedge clock);
   endtask

   task set_run_limit(input int unsigned v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v[RUN_LIMIT_W-1:0];
      @(posedge clock);
      sb.write_limit(v);
      limit_writes++;
      csr_write_enable <= 1'b0;
   endtask

   task random_lines(input int n_items);
      int sent;
      int len;
      int black_pct;
      int r;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 30) begin
            wait_quiet();
            r = $urandom_range(99);
            if (r < 10) set_run_limit(0);
            else if (r < 20) set_run_limit(MAX_RUN);
            else if (r < 70) set_run_limit($urandom_range(1, 8));
            else set_run_limit($urandom_range(0, 63));
         end
         r = $urandom_range(99);
         if (r < 70) len = $urandom_range(1, 24);
         else if (r < 92) len = $urandom_range(25, 80);
         else len = $urandom_range(81, 160);
         r = $urandom_range(99);
         if (r < 10) black_pct = 0;
         else if (r < 20) black_pct = 100;
         else black_pct = $urandom_range(3, 60);
         for (int i = 0; i < len; i++)
            send_pixel($urandom_range(99) < black_pct, i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 85;

      // reset run limit of 8, short closed white runs and runs open at the line ends
      send_line(32'b0000_0000_1001_0010, 12);
      wait_quiet();
      // pass-through, and a one-pixel line
      set_run_limit(0);
      send_line(32'b101, 3);
      send_line(32'b0, 1);
      wait_quiet();
      // largest limit: lines far shorter than c
      set_run_limit(MAX_RUN);
      send_line(32'b1, 1);
      send_line(32'b10010, 5);
      wait_quiet();
      // small limit: white runs open at either line end stay white
      set_run_limit(2);
      send_line(32'b00010, 5);

      random_lines(50);
      wait_quiet();
      send_idle_pct = 85;
      recv_idle_pct = 20;
      random_lines(50);
      wait_quiet();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_lines(50);
      wait_quiet();

      if (sb.pending_beats.size() != 0)
         sb.report($sformatf("%0d beats never arrived", sb.pending_beats.size()));
      $display("covered %0d pixels over %0d line ends with %0d run-limit writes",
               pixels_sent, lines_sent, limit_writes);
      $display("checked %0d smoothed beats, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
